[design/lcw_pkg.sv]
// Package for the line clipper: sequencer state types, register indexes and
// outcode bit positions. No dependencies.
package lcw_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_WIN_LEFT   = 2'd0;
	localparam logic [1:0] REG_WIN_TOP    = 2'd1;
	localparam logic [1:0] REG_WIN_RIGHT  = 2'd2;
	localparam logic [1:0] REG_WIN_BOTTOM = 2'd3;

	// Outcode bit positions
	localparam int OC_BELOW = 0;
	localparam int OC_ABOVE = 1;
	localparam int OC_RIGHT = 2;
	localparam int OC_LEFT  = 3;

	// Most endpoint moves before the final test
	localparam logic [2:0] CLIP_PASSES = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TEST,
		ST_CALC,
		ST_FINISH
	} clip_state_t;

	typedef enum logic [1:0] {
		MD_IDLE,
		MD_MUL,
		MD_DIV,
		MD_DONE
	} md_state_t;

endpackage

[design/lcw_muldiv.sv]
// Shared multiply then serial divide unit: trunc(a*b/d), one quotient bit a cycle.
// Depends on lcw_pkg.
module lcw_muldiv #(
	parameter int COORD_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [COORD_BITS:0]  op_a,
	input  logic signed [COORD_BITS:0]  op_b,
	input  logic signed [COORD_BITS:0]  op_d,
	output logic                        done,
	output logic signed [COORD_BITS+1:0] quot
);
	import lcw_pkg::*;

	localparam int W  = COORD_BITS + 1;
	localparam int PW = 2 * W;
	localparam int CW = $clog2(COORD_BITS + 1);

	md_state_t state_q, state_d;

	logic [W-1:0]      mag_a_q, mag_b_q, mag_d_q;
	logic              neg_q, zero_q;
	logic [W-1:0]      rem_q;
	logic [W-1:0]      low_q;
	logic [W-1:0]      quo_q;
	logic [CW-1:0]     cnt_q;
	logic [PW-1:0]     prod;
	logic [W:0]        rem_sh;
	logic [W:0]        rem_sub;
	logic              take_bit;
	logic              mul_en, div_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			MD_IDLE: begin
				if (start) state_d = MD_MUL;
			end
			MD_MUL:  state_d = MD_DIV;
			MD_DIV: begin
				if (cnt_q == CW'(COORD_BITS)) state_d = MD_DONE;
			end
			MD_DONE: state_d = MD_IDLE;
			default: state_d = MD_IDLE;
		endcase
	end

	always_comb begin
		mul_en = 1'b0;
		div_en = 1'b0;
		done   = 1'b0;
		case (state_q)
			MD_MUL:  mul_en = 1'b1;
			MD_DIV:  div_en = 1'b1;
			MD_DONE: done   = 1'b1;
			default: ;
		endcase
	end

	assign prod     = PW'(mag_a_q) * PW'(mag_b_q);
	assign rem_sh   = {rem_q, low_q[W-1]};
	assign rem_sub  = rem_sh - {1'b0, mag_d_q};
	assign take_bit = (rem_sh >= {1'b0, mag_d_q});

	always_ff @(posedge clk) begin
		if (start && state_q == MD_IDLE) begin
			mag_a_q <= op_a[W-1] ? W'(-op_a) : W'(op_a);
			mag_b_q <= op_b[W-1] ? W'(-op_b) : W'(op_b);
			mag_d_q <= op_d[W-1] ? W'(-op_d) : W'(op_d);
			neg_q   <= op_a[W-1] ^ op_b[W-1] ^ op_d[W-1];
			zero_q  <= (op_d == '0);
		end
		if (mul_en) begin
			// high part seeds the remainder; it stays below the divisor
			rem_q <= prod[PW-1:W];
			low_q <= prod[W-1:0];
			quo_q <= '0;
			cnt_q <= '0;
		end
		if (div_en) begin
			rem_q <= take_bit ? rem_sub[W-1:0] : rem_sh[W-1:0];
			low_q <= {low_q[W-2:0], 1'b0};
			quo_q <= {quo_q[W-2:0], take_bit};
			cnt_q <= cnt_q + CW'(1);
		end
	end

	always_comb begin
		if (zero_q) begin
			quot = '0;
		end else if (neg_q) begin
			quot = -$signed({1'b0, quo_q});
		end else begin
			quot = $signed({1'b0, quo_q});
		end
	end

endmodule

[design/line_clip_to_window.sv]
// Line clipper: clips one segment to the window [left,right) x [top,bottom).
// A segment is first tested by its outcodes; one that they do not settle takes
// endpoint moves (at most four), each worked out by the serial divider.
// One segment is taken at a time; a finished result may wait while the next is taken.
// Reset (arst_n, asynchronous) empties the block and loads the window 0,0 to 1024,768.
// Depends on lcw_pkg and lcw_muldiv.
module line_clip_to_window #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [1:0]                   cfg_index,
	input  logic [COORD_BITS-1:0]        cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] in_x0,
	input  logic signed [COORD_BITS-1:0] in_y0,
	input  logic signed [COORD_BITS-1:0] in_x1,
	input  logic signed [COORD_BITS-1:0] in_y1,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         visible,
	output logic signed [COORD_BITS-1:0] out_x0,
	output logic signed [COORD_BITS-1:0] out_y0,
	output logic signed [COORD_BITS-1:0] out_x1,
	output logic signed [COORD_BITS-1:0] out_y1
);
	import lcw_pkg::*;

	localparam int C = COORD_BITS;
	localparam int W = COORD_BITS + 1;
	localparam logic [C-1:0] RIGHT_RST  = C'(1024);
	localparam logic [C-1:0] BOTTOM_RST = C'(768);

	clip_state_t state_q, state_d;

	logic signed [C-1:0] left_q, top_q, right_q, bottom_q;
	logic signed [C-1:0] x0_q, y0_q, x1_q, y1_q;
	logic [2:0]          pass_q;
	logic                accept_q;
	logic                out_valid_q;
	logic                visible_q;
	logic signed [C-1:0] ox0_q, oy0_q, ox1_q, oy1_q;

	logic [3:0]          c0, c1, co;
	logic                md_start, md_done;
	logic signed [W-1:0] op_a, op_b, op_d;
	logic signed [C+1:0] md_q;
	logic signed [C-1:0] base, edge_val, moved;
	logic signed [C+1:0] moved_w;
	logic                load_in, test_en, fin_load;
	logic                settle_ok, settle_rej;

	function automatic logic signed [W-1:0] sx(input logic signed [C-1:0] v);
		sx = $signed({v[C-1], v});
	endfunction

	// Window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			top_q    <= '0;
			right_q  <= RIGHT_RST;
			bottom_q <= BOTTOM_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_WIN_LEFT:   left_q   <= cfg_data;
				REG_WIN_TOP:    top_q    <= cfg_data;
				REG_WIN_RIGHT:  right_q  <= cfg_data;
				REG_WIN_BOTTOM: bottom_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		c0 = '0;
		c1 = '0;
		if (y0_q >= bottom_q) c0[OC_BELOW] = 1'b1;
		else if (y0_q < top_q) c0[OC_ABOVE] = 1'b1;
		if (x0_q >= right_q) c0[OC_RIGHT] = 1'b1;
		else if (x0_q < left_q) c0[OC_LEFT] = 1'b1;
		if (y1_q >= bottom_q) c1[OC_BELOW] = 1'b1;
		else if (y1_q < top_q) c1[OC_ABOVE] = 1'b1;
		if (x1_q >= right_q) c1[OC_RIGHT] = 1'b1;
		else if (x1_q < left_q) c1[OC_LEFT] = 1'b1;
	end

	assign co         = (c0 != '0) ? c0 : c1;
	assign settle_ok  = ((c0 | c1) == '0);
	assign settle_rej = ((c0 & c1) != '0) || (pass_q == CLIP_PASSES);

	// Operands of the move: pick the edge from the lowest set outcode bit
	always_comb begin
		op_a     = sx(x1_q) - sx(x0_q);
		op_d     = sx(y1_q) - sx(y0_q);
		base     = x0_q;
		op_b     = sx(left_q) - sx(x0_q);
		edge_val = left_q;
		if (co[OC_BELOW]) begin
			op_b     = sx(bottom_q) - sx(y0_q);
			edge_val = bottom_q - C'(1);
		end else if (co[OC_ABOVE]) begin
			op_b     = sx(top_q) - sx(y0_q);
			edge_val = top_q;
		end else begin
			op_a = sx(y1_q) - sx(y0_q);
			op_d = sx(x1_q) - sx(x0_q);
			base = y0_q;
			if (co[OC_RIGHT]) begin
				op_b     = sx(right_q) - sx(x0_q);
				edge_val = right_q - C'(1);
			end
		end
	end

	assign moved_w = $signed({{2{base[C-1]}}, base}) + md_q;
	assign moved   = moved_w[C-1:0];

	lcw_muldiv #(
		.COORD_BITS(COORD_BITS)
	) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (md_start),
		.op_a   (op_a),
		.op_b   (op_b),
		.op_d   (op_d),
		.done   (md_done),
		.quot   (md_q)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_TEST;
			end
			ST_TEST: begin
				if (settle_ok || settle_rej) state_d = ST_FINISH;
				else state_d = ST_CALC;
			end
			ST_CALC: begin
				if (md_done) state_d = ST_TEST;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		load_in  = 1'b0;
		test_en  = 1'b0;
		md_start = 1'b0;
		fin_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				load_in  = in_valid;
			end
			ST_TEST: begin
				test_en  = 1'b1;
				md_start = !(settle_ok || settle_rej);
			end
			ST_FINISH: fin_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_in) begin
			x0_q   <= in_x0;
			y0_q   <= in_y0;
			x1_q   <= in_x1;
			y1_q   <= in_y1;
			pass_q <= '0;
		end
		if (test_en) begin
			accept_q <= settle_ok;
		end
		if (state_q == ST_CALC && md_done) begin
			// move the first endpoint that lies outside
			pass_q <= pass_q + 3'd1;
			if (c0 != '0) begin
				if (co[OC_BELOW] || co[OC_ABOVE]) begin
					x0_q <= moved;
					y0_q <= edge_val;
				end else begin
					x0_q <= edge_val;
					y0_q <= moved;
				end
			end else begin
				if (co[OC_BELOW] || co[OC_ABOVE]) begin
					x1_q <= moved;
					y1_q <= edge_val;
				end else begin
					x1_q <= edge_val;
					y1_q <= moved;
				end
			end
		end
		if (fin_load) begin
			visible_q <= accept_q;
			ox0_q     <= accept_q ? x0_q : '0;
			oy0_q     <= accept_q ? y0_q : '0;
			ox1_q     <= accept_q ? x1_q : '0;
			oy1_q     <= accept_q ? y1_q : '0;
		end
	end

	// Result register: hold until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign visible   = visible_q;
	assign out_x0    = ox0_q;
	assign out_y0    = oy0_q;
	assign out_x1    = ox1_q;
	assign out_y1    = oy1_q;

endmodule
